// File: hdl/dcpc_pkg.sv
// ----------------------------------------------------------------------------
// dcpc_pkg
// shared types, register codes and channel pack/unpack functions for the
// direct-color pixel converter
// ----------------------------------------------------------------------------
package dcpc_pkg;

    localparam int CHAN_W  = 16;
    localparam int PIXEL_W = 32;
    localparam int CFG_W   = 5;
    localparam int IDX_W   = 3;

    // action codes
    localparam logic ACT_PACK   = 1'b0;
    localparam logic ACT_UNPACK = 1'b1;

    // register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_RED_SHIFT   = 3'd0,
        REG_RED_WIDTH   = 3'd1,
        REG_GREEN_SHIFT = 3'd2,
        REG_GREEN_WIDTH = 3'd3,
        REG_BLUE_SHIFT  = 3'd4,
        REG_BLUE_WIDTH  = 3'd5,
        REG_ALPHA_SHIFT = 3'd6,
        REG_ALPHA_WIDTH = 3'd7
    } reg_idx_t;

    // reset values of the format registers
    localparam logic [CFG_W-1:0] RST_RED_SHIFT   = 5'd16;
    localparam logic [CFG_W-1:0] RST_GREEN_SHIFT = 5'd8;
    localparam logic [CFG_W-1:0] RST_BLUE_SHIFT  = 5'd0;
    localparam logic [CFG_W-1:0] RST_ALPHA_SHIFT = 5'd24;
    localparam logic [CFG_W-1:0] RST_WIDTH       = 5'd8;

    typedef struct packed {
        logic [CFG_W-1:0] shift;
        logic [CFG_W-1:0] width;
    } chan_fmt_t;

    typedef struct packed {
        chan_fmt_t red;
        chan_fmt_t green;
        chan_fmt_t blue;
        chan_fmt_t alpha;
    } pix_fmt_t;

    typedef struct packed {
        logic              action;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic [PIXEL_W-1:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  alpha;
    } out_item_t;

    // width saturated to a full channel
    function automatic logic [CFG_W-1:0] eff_width(input logic [CFG_W-1:0] w);
        return (w > CFG_W'(CHAN_W)) ? CFG_W'(CHAN_W) : w;
    endfunction

    // keep the top bits of a channel and move them to their offset
    function automatic logic [PIXEL_W-1:0] pack_chan(
        input logic [CHAN_W-1:0] v,
        input logic [CFG_W-1:0]  shift,
        input logic [CFG_W-1:0]  width
    );
        logic [CFG_W-1:0]   w;
        logic [CHAN_W-1:0]  top;
        w   = eff_width(width);
        top = v >> (CFG_W'(CHAN_W) - w);
        if (w == '0)
        begin
            return '0;
        end
        return PIXEL_W'(top) << shift;
    endfunction

    // extract a field and widen it by repeated doubling
    function automatic logic [CHAN_W-1:0] unpack_chan(
        input logic [PIXEL_W-1:0] pixel,
        input logic [CFG_W-1:0]   shift,
        input logic [CFG_W-1:0]   width
    );
        logic [CFG_W-1:0]  w;
        logic [CHAN_W:0]   mask;
        logic [CHAN_W-1:0] v;
        logic [CFG_W:0]    bits;
        w    = eff_width(width);
        mask = (17'd1 << w) - 17'd1;
        v    = CHAN_W'(pixel >> shift) & mask[CHAN_W-1:0];
        bits = {1'b0, w};
        // at most four doublings from a one-bit field
        for (int i = 0; i < 4; i++)
        begin
            if (bits < (CFG_W+1)'(CHAN_W))
            begin
                v    = v | (v << bits[CFG_W-2:0]);
                bits = bits << 1;
            end
        end
        if (w == '0)
        begin
            return '0;
        end
        return v;
    endfunction

endpackage

// File: hdl/direct_color_pixel_convert_core.sv
// ----------------------------------------------------------------------------
// direct_color_pixel_convert_core
// stream converter between 16-bit-per-channel rgba and a packed pixel
// ----------------------------------------------------------------------------
// The core takes one beat per clock while the output is not stalled and
// returns one beat for each beat taken, in order. A beat with tuser low packs
// the four colors into a pixel; a beat with tuser high unpacks the pixel into
// four widened colors. A beat passes one input register, then the conversion
// in a single pass into the result register. Throughput is one beat per clock,
// set by that single pass; a stalled result register stops input only once
// the input register is full. Format registers must be written through cfg_we/
// cfg_index/cfg_data while the core holds no beat; the core does not enforce it.
module direct_color_pixel_convert_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // red_in[15:0], green_in[31:16], blue_in[47:32], alpha_in[63:48],
    // pixel_in[95:64]
    input  logic [95:0] s_axis_tdata,
    // action[0]
    input  logic        s_axis_tuser,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_out[31:0], red_out[47:32], green_out[63:48], blue_out[79:64],
    // alpha_out[95:80]
    output logic [95:0] m_axis_tdata
);

    dcpc_pkg::pix_fmt_t  fmt;
    dcpc_pkg::in_item_t  in_item_reg;
    dcpc_pkg::out_item_t result;
    dcpc_pkg::out_item_t out_item_reg;
    logic                in_valid_reg;
    logic                out_valid_reg;
    logic                advance;
    logic                s_accept;

    dcpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fmt       (fmt)
    );

    dcpc_convert u_convert (
        .item   (in_item_reg),
        .fmt    (fmt),
        .result (result)
    );

    // handshake: result register frees when empty or taken
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // input beat register
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.action <= s_axis_tuser;
            in_item_reg.red    <= s_axis_tdata[15:0];
            in_item_reg.green  <= s_axis_tdata[31:16];
            in_item_reg.blue   <= s_axis_tdata[47:32];
            in_item_reg.alpha  <= s_axis_tdata[63:48];
            in_item_reg.pixel  <= s_axis_tdata[95:64];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_item_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_item_reg.alpha, out_item_reg.blue,
                            out_item_reg.green, out_item_reg.red,
                            out_item_reg.pixel};

    // no beat taken while both stages are full and the output stalls
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |-> !(in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input beat taken with pipeline full");

    // a held beat stays in the input register
    a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input beat lost under stall");

    // a beat leaving the input register shows up as a result
    a_move_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> out_valid_reg)
        else $error("beat dropped between stages");

    // a packed pixel result carries no colors
    a_pack_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_item_reg.pixel != '0)) |->
        ((out_item_reg.red == '0) && (out_item_reg.green == '0) &&
         (out_item_reg.blue == '0) && (out_item_reg.alpha == '0)))
        else $error("pack and unpack fields both set");

endmodule

// File: hdl/dcpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// dcpc_cfg_regs
// pixel format register file, written through a plain write port
// ----------------------------------------------------------------------------
module dcpc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dcpc_pkg::IDX_W-1:0]     cfg_index,
    input  logic [dcpc_pkg::CFG_W-1:0]     cfg_data,
    output dcpc_pkg::pix_fmt_t             fmt
);

    dcpc_pkg::pix_fmt_t fmt_reg;
    dcpc_pkg::pix_fmt_t fmt_next;

    // register write decode
    always_comb
    begin
        fmt_next = fmt_reg;
        if (cfg_we)
        begin
            unique case (dcpc_pkg::reg_idx_t'(cfg_index))
                dcpc_pkg::REG_RED_SHIFT:   fmt_next.red.shift   = cfg_data;
                dcpc_pkg::REG_RED_WIDTH:   fmt_next.red.width   = cfg_data;
                dcpc_pkg::REG_GREEN_SHIFT: fmt_next.green.shift = cfg_data;
                dcpc_pkg::REG_GREEN_WIDTH: fmt_next.green.width = cfg_data;
                dcpc_pkg::REG_BLUE_SHIFT:  fmt_next.blue.shift  = cfg_data;
                dcpc_pkg::REG_BLUE_WIDTH:  fmt_next.blue.width  = cfg_data;
                dcpc_pkg::REG_ALPHA_SHIFT: fmt_next.alpha.shift = cfg_data;
                dcpc_pkg::REG_ALPHA_WIDTH: fmt_next.alpha.width = cfg_data;
                default:                   fmt_next = fmt_reg;
            endcase
        end
    end

    // format registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg.red.shift   <= dcpc_pkg::RST_RED_SHIFT;
            fmt_reg.red.width   <= dcpc_pkg::RST_WIDTH;
            fmt_reg.green.shift <= dcpc_pkg::RST_GREEN_SHIFT;
            fmt_reg.green.width <= dcpc_pkg::RST_WIDTH;
            fmt_reg.blue.shift  <= dcpc_pkg::RST_BLUE_SHIFT;
            fmt_reg.blue.width  <= dcpc_pkg::RST_WIDTH;
            fmt_reg.alpha.shift <= dcpc_pkg::RST_ALPHA_SHIFT;
            fmt_reg.alpha.width <= dcpc_pkg::RST_WIDTH;
        end
        else
        begin
            fmt_reg <= fmt_next;
        end
    end

    assign fmt = fmt_reg;

endmodule

// File: hdl/dcpc_convert.sv
// ----------------------------------------------------------------------------
// dcpc_convert
// single-pass pack or unpack of one beat under the current pixel format
// ----------------------------------------------------------------------------
module dcpc_convert (
    input  dcpc_pkg::in_item_t  item,
    input  dcpc_pkg::pix_fmt_t  fmt,
    output dcpc_pkg::out_item_t result
);

    logic [dcpc_pkg::PIXEL_W-1:0] packed_pix;

    // pack: or the four placed channels together
    assign packed_pix =
        dcpc_pkg::pack_chan(item.red,   fmt.red.shift,   fmt.red.width)   |
        dcpc_pkg::pack_chan(item.green, fmt.green.shift, fmt.green.width) |
        dcpc_pkg::pack_chan(item.blue,  fmt.blue.shift,  fmt.blue.width)  |
        dcpc_pkg::pack_chan(item.alpha, fmt.alpha.shift, fmt.alpha.width);

    // select pack or unpack result, unused fields zero
    always_comb
    begin
        result = '0;
        if (item.action == dcpc_pkg::ACT_UNPACK)
        begin
            result.red   = dcpc_pkg::unpack_chan(item.pixel, fmt.red.shift,
                                                 fmt.red.width);
            result.green = dcpc_pkg::unpack_chan(item.pixel, fmt.green.shift,
                                                 fmt.green.width);
            result.blue  = dcpc_pkg::unpack_chan(item.pixel, fmt.blue.shift,
                                                 fmt.blue.width);
            result.alpha = dcpc_pkg::unpack_chan(item.pixel, fmt.alpha.shift,
                                                 fmt.alpha.width);
        end
        else
        begin
            result.pixel = packed_pix;
        end
    end

endmodule
